// ----- hw/rtl/command_line_tokenizer_macros.svh -----
// assertion macros shared by the tokenizer rtl
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// checked property, suspended while reset is high
`define CLT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds through reset
`define CLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/clt_pkg.sv -----
// types and constants of the command line tokenizer
`timescale 1ns / 1ps

package clt_pkg;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_GT     = 16'h003E;
  localparam logic [15:0] CH_TWO    = 16'h0032;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_CR     = 16'h000D;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_NEL    = 16'h0085;
  localparam logic [15:0] CH_NBSP   = 16'h00A0;

  // results one item can cause, and depth of the result queue
  localparam int MAX_RES   = 3;
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);
  localparam int NUM_W     = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic in_quote;
    logic escape_pending;
    logic token_nonempty;
    logic token_is_two;
  } tok_state_t;

  typedef struct packed {
    logic [15:0] code_unit_res;
    logic        is_char;
    logic        token_end;
    logic        line_done;
  } result_t;

  localparam tok_state_t STATE_RESET = '0;

endpackage

// ----- hw/rtl/clt_if.sv -----
// valid/ready channel interfaces for characters in and results out
`timescale 1ns / 1ps

interface clt_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_line;

  modport source (output valid, output code_unit, output end_of_line, input ready);
  modport sink (input valid, input code_unit, input end_of_line, output ready);
endinterface

interface clt_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit_res;
  logic        is_char;
  logic        token_end;
  logic        line_done;

  modport source (output valid, output code_unit_res, output is_char, output token_end,
                  output line_done, input ready);
  modport sink (input valid, input code_unit_res, input is_char, input token_end,
                input line_done, output ready);
endinterface

// ----- hw/rtl/command_line_tokenizer.sv -----
// Command line tokenizer top level. One character beat is taken per clock while
// input is ready: its decode and the state update are done in the accepting
// cycle, and its zero to three results go into a four-entry result queue that
// feeds the output channel one result per clock while the output is ready.
// Input is ready whenever the queue holds at most one result, so plain
// characters stream at one beat per cycle while the output takes a result every
// cycle; if the output stalls, input stops once two results wait. An unquoted
// '>' makes up to three results that leave the output one at a time, which
// sets the sustained rate on lines with redirections. When the queue is empty,
// the first result of an accepted beat appears in the next cycle.
`timescale 1ns / 1ps
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer (
  input logic         clk,
  input logic         rst,
  clt_char_if.sink    chars,
  clt_res_if.source   results
);
  import clt_pkg::*;

  tok_state_t                 state;
  tok_state_t                 state_next;
  result_t [MAX_RES-1:0]      res;
  logic [NUM_W-1:0]           res_num;
  result_t                    queue [RES_DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           rd_ptr;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic                       push;
  logic                       pop;
  logic [NUM_W-1:0]           push_num;

  clt_step u_step (
    .state       (state),
    .code_unit   (chars.code_unit),
    .end_of_line (chars.end_of_line),
    .state_next  (state_next),
    .res         (res),
    .res_num     (res_num)
  );

  // room for a full burst is judged from registered fill only
  assign chars.ready = count <= CNT_W'(RES_DEPTH - MAX_RES);
  assign push = chars.valid && chars.ready;
  assign pop = results.valid && results.ready;
  assign push_num = push ? res_num : '0;
  assign count_next = count + CNT_W'(push_num) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        state <= state_next;
      end
      count <= count_next;
      wr_ptr <= wr_ptr + PTR_W'(push_num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && i < int'(res_num)) begin
        queue[wr_ptr + PTR_W'(i)] <= res[i];
      end
    end
  end

  assign results.valid = count != '0;
  assign results.code_unit_res = queue[rd_ptr].code_unit_res;
  assign results.is_char = queue[rd_ptr].is_char;
  assign results.token_end = queue[rd_ptr].token_end;
  assign results.line_done = queue[rd_ptr].line_done;

  `CLT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !results.valid, "queue not empty after reset")
  `CLT_ASSERT(a_fill_bound, clk, rst, count <= CNT_W'(RES_DEPTH), "result queue overfilled")
  `CLT_ASSERT(a_fill_track, clk, rst, wr_ptr == rd_ptr + PTR_W'(count), "pointers vs fill")
  `CLT_ASSERT(a_char_xor_end, clk, rst, results.valid |-> !(results.is_char && results.token_end), "char and end")
  `CLT_ASSERT(a_eol_clears, clk, rst, push && chars.end_of_line |=> state == STATE_RESET, "eol state")

endmodule

// ----- hw/rtl/clt_step.sv -----
// per-character decode: results of one beat and the next tokenizer state
`timescale 1ns / 1ps

module clt_step (
  input  clt_pkg::tok_state_t                     state,
  input  logic [15:0]                             code_unit,
  input  logic                                    end_of_line,
  output clt_pkg::tok_state_t                     state_next,
  output clt_pkg::result_t [clt_pkg::MAX_RES-1:0] res,
  output logic [clt_pkg::NUM_W-1:0]               res_num
);
  import clt_pkg::*;

  logic ws;

  assign ws = (code_unit >= CH_TAB && code_unit <= CH_CR) || code_unit == CH_SPACE ||
              code_unit == CH_NEL || code_unit == CH_NBSP;

  always_comb begin
    tok_state_t s;
    logic [NUM_W-1:0] n;
    s = state;
    n = '0;
    res = '0;

    if (end_of_line) begin
      res[0].token_end = state.token_nonempty;
      res[0].line_done = 1'b1;
      n = NUM_W'(1);
      s = STATE_RESET;
    end else begin
      if (code_unit == CH_GT && !state.in_quote && !state.token_is_two) begin
        // stray '>' first closes whatever token is open
        if (s.token_nonempty) begin
          res[n[PTR_W-1:0]].token_end = 1'b1;
          n = n + NUM_W'(1);
        end
        s.token_nonempty = 1'b0;
        s.token_is_two = 1'b0;
      end

      if (ws && !state.in_quote) begin
        if (s.token_nonempty) begin
          res[n[PTR_W-1:0]].token_end = 1'b1;
          n = n + NUM_W'(1);
        end
        s.token_nonempty = 1'b0;
        s.token_is_two = 1'b0;
      end else begin
        // every other case appends the character
        res[n[PTR_W-1:0]].code_unit_res = code_unit;
        res[n[PTR_W-1:0]].is_char = 1'b1;
        n = n + NUM_W'(1);
        s.token_is_two = !s.token_nonempty && code_unit == CH_TWO;
        s.token_nonempty = 1'b1;
      end

      if (code_unit == CH_GT && !state.in_quote) begin
        // redirect ends its token after the '>'
        res[n[PTR_W-1:0]].token_end = 1'b1;
        n = n + NUM_W'(1);
        s.token_nonempty = 1'b0;
        s.token_is_two = 1'b0;
      end

      if (code_unit == CH_QUOTE && !state.escape_pending) begin
        s.in_quote = !state.in_quote;
      end

      s.escape_pending = (code_unit == CH_BSLASH) ? !state.escape_pending : 1'b0;
    end

    state_next = s;
    res_num = n;
  end

endmodule
